// File: rtl/wss_pkg.sv
package wss_pkg;

  // Default number of stored events for each day of the week.
  localparam int EventsPerDayDef = 16;

  localparam int          NumDays        = 7;
  localparam logic [2:0]  LastDay        = 3'd6;
  localparam logic [11:0] DefaultSpReset = 12'd288;

  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_APPEND = 2'd1,
    OP_QUERY  = 2'd2,
    OP_NONE   = 2'd3
  } op_e;

  localparam logic [1:0] SrcToday   = 2'd0;
  localparam logic [1:0] SrcPrevDay = 2'd1;
  localparam logic [1:0] SrcDefault = 2'd2;

  // One stored event: start time and its setpoint.
  typedef struct packed {
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [11:0] setpoint;
  } event_t;

endpackage

// File: rtl/wss_if.sv
interface wss_in_if;
  logic              valid;
  logic              ready;
  logic [1:0]        op;
  logic [2:0]        weekday;
  logic [4:0]        hour;
  logic [5:0]        minute;
  logic signed [11:0] event_setpoint;
  logic              time_known;

  modport source (output valid, op, weekday, hour, minute, event_setpoint, time_known,
                  input ready);
  modport sink   (input valid, op, weekday, hour, minute, event_setpoint, time_known,
                  output ready);
endinterface

interface wss_out_if;
  logic               valid;
  logic               ready;
  logic signed [11:0] active_setpoint;
  logic               setpoint_valid;
  logic [1:0]         src;
  logic               status;

  modport source (output valid, active_setpoint, setpoint_valid, src, status,
                  input ready);
  modport sink   (input valid, active_setpoint, setpoint_valid, src, status,
                  output ready);
endinterface

interface wss_cfg_if;
  logic               valid;
  logic               ready;
  logic signed [11:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

// File: rtl/weekly_setpoint_schedule_top.sv
// Items other than walking queries go from idle straight to the finish state, which loads
// the result register once the output is free. A query with known time walks the day's events,
// one compared per cycle; if none has started yet, it then reads the previous day's last event.
// Input is ready again in the cycle after the result loads.
// Reset clears the day counts and the sequencer and sets the default setpoint to 18.0
// degrees; the event memory itself is not cleared.
module weekly_setpoint_schedule_top #(
  parameter int EVENTS_PER_DAY = wss_pkg::EventsPerDayDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  wss_in_if.sink    in_i,
  wss_out_if.source out_o,
  wss_cfg_if.sink   cfg_i
);
  import wss_pkg::*;

  localparam int ADDR_W = $clog2(NumDays * EVENTS_PER_DAY);
  localparam int CNT_W  = $clog2(EVENTS_PER_DAY + 1);

  localparam logic [2:0] StIdle   = 3'd0;
  localparam logic [2:0] StStart  = 3'd1;
  localparam logic [2:0] StWalk   = 3'd2;
  localparam logic [2:0] StPrev   = 3'd3;
  localparam logic [2:0] StPrevRd = 3'd4;
  localparam logic [2:0] StFinish = 3'd5;

  logic [2:0]       state_q, state_d;
  logic [CNT_W-1:0] cnt_q [NumDays];
  logic [CNT_W-1:0] cnt_d [NumDays];
  logic [CNT_W-1:0] idx_q, idx_d;
  logic [2:0]       day_q, day_d;
  logic [10:0]      now_q, now_d;
  logic             found_q, found_d;
  logic [11:0]      default_sp_q;

  logic [11:0] r_sp_q, r_sp_d;
  logic        r_valid_q, r_valid_d;
  logic [1:0]  r_src_q, r_src_d;
  logic        r_status_q, r_status_d;

  logic        out_valid_q, out_valid_d;
  logic [11:0] out_sp_q, out_sp_d;
  logic        out_spv_q, out_spv_d;
  logic [1:0]  out_src_q, out_src_d;
  logic        out_status_q, out_status_d;

  logic              mem_we, mem_re;
  logic [ADDR_W-1:0] mem_waddr, mem_raddr;
  event_t            mem_wdata, rd_ev;

  logic [CNT_W-1:0] cnt_in, cnt_day, cnt_prev;
  logic [2:0]       prev_day;
  logic [CNT_W-1:0] idx_next;

  function automatic logic [ADDR_W-1:0] day_base(input logic [2:0] day);
    day_base = ADDR_W'(day) * ADDR_W'(EVENTS_PER_DAY);
  endfunction

  wss_event_mem #(
    .EventsPerDay(EVENTS_PER_DAY)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (rd_ev)
  );

  assign in_i.ready  = (state_q == StIdle);
  assign cfg_i.ready = 1'b1;

  assign out_o.valid           = out_valid_q;
  assign out_o.active_setpoint = out_sp_q;
  assign out_o.setpoint_valid  = out_spv_q;
  assign out_o.src             = out_src_q;
  assign out_o.status          = out_status_q;

  assign cnt_in   = (in_i.weekday <= LastDay) ? cnt_q[in_i.weekday] : '0;
  assign cnt_day  = (day_q <= LastDay) ? cnt_q[day_q] : '0;
  assign prev_day = (day_q == 3'd0) ? LastDay : day_q - 3'd1;
  assign cnt_prev = cnt_q[prev_day];
  assign idx_next = idx_q + CNT_W'(1);

  assign mem_wdata = '{hour: in_i.hour, minute: in_i.minute, setpoint: in_i.event_setpoint};
  assign mem_waddr = day_base(in_i.weekday) + ADDR_W'(cnt_in);

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    idx_d      = idx_q;
    day_d      = day_q;
    now_d      = now_q;
    found_d    = found_q;
    r_sp_d     = r_sp_q;
    r_valid_d  = r_valid_q;
    r_src_d    = r_src_q;
    r_status_d = r_status_q;
    mem_we     = 1'b0;
    mem_re     = 1'b0;
    mem_raddr  = day_base(day_q) + ADDR_W'(idx_next);

    out_valid_d  = out_valid_q & ~out_o.ready;
    out_sp_d     = out_sp_q;
    out_spv_d    = out_spv_q;
    out_src_d    = out_src_q;
    out_status_d = out_status_q;

    case (state_q)
      StIdle: begin
        if (in_i.valid) begin
          r_sp_d     = '0;
          r_valid_d  = 1'b0;
          r_src_d    = SrcToday;
          r_status_d = 1'b0;
          found_d    = 1'b0;
          day_d      = in_i.weekday;
          now_d      = {in_i.hour, in_i.minute};
          state_d    = StFinish;
          case (op_e'(in_i.op))
            OP_CLEAR: begin
              for (int d = 0; d < NumDays; d++) begin
                cnt_d[d] = '0;
              end
            end
            OP_APPEND: begin
              if (in_i.weekday > LastDay || cnt_in >= CNT_W'(EVENTS_PER_DAY)) begin
                r_status_d = 1'b1;
              end else begin
                mem_we                = 1'b1;
                cnt_d[in_i.weekday] = cnt_in + CNT_W'(1);
              end
            end
            OP_QUERY: begin
              if (in_i.time_known && in_i.weekday <= LastDay) begin
                r_sp_d    = default_sp_q;
                r_src_d   = SrcDefault;
                r_valid_d = 1'b1;
                state_d   = StStart;
              end
            end
            default: begin
            end
          endcase
        end
      end
      StStart: begin
        idx_d = '0;
        if (cnt_day != '0) begin
          mem_re    = 1'b1;
          mem_raddr = day_base(day_q);
          state_d   = StWalk;
        end else begin
          state_d = StPrev;
        end
      end
      StWalk: begin
        // The read data belongs to entry idx_q; the next entry is read alongside.
        if ({rd_ev.hour, rd_ev.minute} <= now_q) begin
          r_sp_d  = rd_ev.setpoint;
          r_src_d = SrcToday;
          found_d = 1'b1;
          if (idx_next < cnt_day) begin
            mem_re = 1'b1;
            idx_d  = idx_next;
          end else begin
            state_d = StFinish;
          end
        end else if (found_q) begin
          state_d = StFinish;
        end else begin
          state_d = StPrev;
        end
      end
      StPrev: begin
        if (cnt_prev != '0) begin
          mem_re    = 1'b1;
          mem_raddr = day_base(prev_day) + ADDR_W'(cnt_prev - CNT_W'(1));
          state_d   = StPrevRd;
        end else begin
          state_d = StFinish;
        end
      end
      StPrevRd: begin
        r_sp_d  = rd_ev.setpoint;
        r_src_d = SrcPrevDay;
        state_d = StFinish;
      end
      StFinish: begin
        if (!out_valid_q || out_o.ready) begin
          out_valid_d  = 1'b1;
          out_sp_d     = r_sp_q;
          out_spv_d    = r_valid_q;
          out_src_d    = r_src_q;
          out_status_d = r_status_q;
          state_d      = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StIdle;
      out_valid_q  <= 1'b0;
      default_sp_q <= DefaultSpReset;
      for (int d = 0; d < NumDays; d++) begin
        cnt_q[d] <= '0;
      end
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      cnt_q       <= cnt_d;
      if (cfg_i.valid) begin
        default_sp_q <= cfg_i.data;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q        <= idx_d;
    day_q        <= day_d;
    now_q        <= now_d;
    found_q      <= found_d;
    r_sp_q       <= r_sp_d;
    r_valid_q    <= r_valid_d;
    r_src_q      <= r_src_d;
    r_status_q   <= r_status_d;
    out_sp_q     <= out_sp_d;
    out_spv_q    <= out_spv_d;
    out_src_q    <= out_src_d;
    out_status_q <= out_status_d;
  end

endmodule

// File: rtl/wss_event_mem.sv
module wss_event_mem #(
  parameter int EventsPerDay = wss_pkg::EventsPerDayDef
) (
  input  logic                                       clk_i,
  input  logic                                       we_i,
  input  logic [$clog2(wss_pkg::NumDays*EventsPerDay)-1:0] waddr_i,
  input  wss_pkg::event_t                            wdata_i,
  input  logic                                       re_i,
  input  logic [$clog2(wss_pkg::NumDays*EventsPerDay)-1:0] raddr_i,
  output wss_pkg::event_t                            rdata_o
);
  import wss_pkg::*;

  localparam int Depth = NumDays * EventsPerDay;

  event_t mem_q [Depth];
  event_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: bench/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import wss_pkg::*;

  localparam int EventsPerDay  = EventsPerDayDef;
  localparam int PhaseCount    = 13;
  localparam int PhaseItems    = 150;
  localparam int DrainCycles   = 2 * (EventsPerDay + 5);
  localparam int TimeoutCycles = 600000;

  typedef struct packed {
    op_e         op;
    logic [2:0]  weekday;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [11:0] setpoint;
    logic        time_known;
  } sched_item_t;

  typedef struct packed {
    logic [11:0] setpoint;
    logic        valid;
    logic [1:0]  src;
    logic        status;
  } sched_answer_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  wss_in_if  in_if ();
  wss_out_if out_if ();
  wss_cfg_if cfg_if ();

  // Our own copy of the schedule, kept in step with accepted transactions.
  event_t      day_events [NumDays][EventsPerDay];
  int          day_count [NumDays];
  logic [11:0] default_sp = DefaultSpReset;

  sched_item_t   pending_items [$];
  sched_answer_t expected_answers [$];
  sched_item_t   next_item;

  bit          in_taken, out_taken, cfg_taken;
  int          in_gap, out_wait;
  bit          no_idle;
  int unsigned queued_total, accepted_total, answered_total;
  int unsigned error_count;

  weekly_setpoint_schedule_top #(
    .EVENTS_PER_DAY(EventsPerDay)
  ) DUT (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if),
    .cfg_i (cfg_if)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  function automatic int draw_wait();
    return no_idle ? 0 : $urandom_range(0, 12);
  endfunction

  function automatic void queue_item(op_e op, int wd, int hr, int mn, int sp, int known);
    sched_item_t it;
    it.op         = op;
    it.weekday    = wd[2:0];
    it.hour       = hr[4:0];
    it.minute     = mn[5:0];
    it.setpoint   = sp[11:0];
    it.time_known = known[0];
    pending_items = {pending_items, it};
    queued_total++;
  endfunction

  function automatic sched_answer_t schedule_answer(sched_item_t it);
    sched_answer_t ans;
    logic [2:0]    prev_day;
    int            idx;
    bit            hit;
    bit            stop;
    ans = '0;
    case (it.op)
      OP_CLEAR: begin
        for (idx = 0; idx < NumDays; idx++) day_count[idx] = 0;
      end
      OP_APPEND: begin
        if (it.weekday > LastDay) begin
          ans.status = 1'b1;
        end else if (day_count[it.weekday] >= EventsPerDay) begin
          ans.status = 1'b1;
        end else begin
          day_events[it.weekday][day_count[it.weekday]] = '{it.hour, it.minute, it.setpoint};
          day_count[it.weekday]++;
        end
      end
      OP_QUERY: begin
        if (it.time_known && it.weekday <= LastDay) begin
          ans.setpoint = default_sp;
          ans.src      = SrcDefault;
          ans.valid    = 1'b1;
          hit  = 1'b0;
          stop = 1'b0;
          idx  = 0;
          // The walk ends at the first event that starts after the query time.
          while (!stop && idx < day_count[it.weekday]) begin
            if ({it.hour, it.minute} >= {day_events[it.weekday][idx].hour,
                                         day_events[it.weekday][idx].minute}) begin
              ans.setpoint = day_events[it.weekday][idx].setpoint;
              ans.src      = SrcToday;
              hit          = 1'b1;
              idx++;
            end else begin
              stop = 1'b1;
            end
          end
          if (!hit) begin
            prev_day = (it.weekday == 3'd0) ? LastDay : it.weekday - 3'd1;
            if (day_count[prev_day] > 0) begin
              ans.setpoint = day_events[prev_day][day_count[prev_day] - 1].setpoint;
              ans.src      = SrcPrevDay;
            end
          end
        end
      end
      default: ;
    endcase
    return ans;
  endfunction

  function automatic void report_mismatch(string field, int want, int got);
    error_count++;
    $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
  endfunction

  task automatic wait_drained();
    while (accepted_total < queued_total || answered_total < accepted_total) begin
      @(negedge clk_i);
    end
  endtask

  // Input driver: holds an item until its transaction completes.
  always @(negedge clk_i) begin
    if (rst_ni && (!in_if.valid || in_taken)) begin
      if (in_taken) in_gap = draw_wait();
      if (in_gap > 0) begin
        in_gap--;
        in_if.valid <= 1'b0;
      end else if (pending_items.size() > 0) begin
        next_item = pending_items.pop_front();
        in_if.op             <= next_item.op;
        in_if.weekday        <= next_item.weekday;
        in_if.hour           <= next_item.hour;
        in_if.minute         <= next_item.minute;
        in_if.event_setpoint <= next_item.setpoint;
        in_if.time_known     <= next_item.time_known;
        in_if.valid          <= 1'b1;
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // Result sink: after each result it stalls for a drawn number of cycles.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (out_taken) out_wait = draw_wait();
      if (out_wait > 0) begin
        out_wait--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin : monitor
    sched_answer_t got;
    sched_answer_t want;
    sched_item_t   seen;
    if (rst_ni) begin
      in_taken  <= in_if.valid && in_if.ready;
      out_taken <= out_if.valid && out_if.ready;
      cfg_taken <= cfg_if.valid && cfg_if.ready;
      if (cfg_if.valid && cfg_if.ready) default_sp = cfg_if.data;
      // Results are checked before the new input is predicted, as they are older.
      if (out_if.valid && out_if.ready) begin
        got = '{out_if.active_setpoint, out_if.setpoint_valid, out_if.src, out_if.status};
        answered_total <= answered_total + 1;
        if (expected_answers.size() == 0) begin
          error_count++;
          $display("%0t: unexpected result, expected none, got sp %0d valid %0d src %0d st %0d",
                   $time, $signed(got.setpoint), got.valid, got.src, got.status);
        end else begin
          want = expected_answers.pop_front();
          if (got.setpoint !== want.setpoint) begin
            report_mismatch("active_setpoint", $signed(want.setpoint), $signed(got.setpoint));
          end
          if (got.valid !== want.valid) report_mismatch("setpoint_valid", want.valid, got.valid);
          if (got.src !== want.src) report_mismatch("source", want.src, got.src);
          if (got.status !== want.status) report_mismatch("status", want.status, got.status);
        end
      end
      if (in_if.valid && in_if.ready) begin
        seen.op         = op_e'(in_if.op);
        seen.weekday    = in_if.weekday;
        seen.hour       = in_if.hour;
        seen.minute     = in_if.minute;
        seen.setpoint   = in_if.event_setpoint;
        seen.time_known = in_if.time_known;
        expected_answers = {expected_answers, schedule_answer(seen)};
        accepted_total <= accepted_total + 1;
      end
    end
  end

  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < TimeoutCycles) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("testbench failed");
    $finish;
  end

  initial begin : stimulus
    int phase;
    int made;
    int choice;
    int day;
    int n;
    int k;
    int t;
    int value;
    bit sorted;
    rst_ni               = 1'b0;
    in_if.valid          = 1'b0;
    in_if.op             = OP_CLEAR;
    in_if.weekday        = '0;
    in_if.hour           = '0;
    in_if.minute         = '0;
    in_if.event_setpoint = '0;
    in_if.time_known     = 1'b0;
    out_if.ready         = 1'b0;
    cfg_if.valid         = 1'b0;
    cfg_if.data          = '0;
    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Empty schedule: default answer, unknown time, invalid day, idle op, bad append.
    queue_item(OP_QUERY, 3, 12, 0, 0, 1);
    queue_item(OP_QUERY, 3, 12, 0, 0, 0);
    queue_item(OP_QUERY, 7, 12, 0, 0, 1);
    queue_item(OP_NONE, 7, 31, 63, -1, 1);
    queue_item(OP_APPEND, 7, 10, 0, 55, 1);
    queue_item(OP_APPEND, 0, 6, 0, 2047, 0);
    queue_item(OP_APPEND, 0, 8, 30, -2048, 1);
    queue_item(OP_APPEND, 6, 22, 0, 100, 0);
    // Early on Sunday the answer comes from Saturday's last event.
    queue_item(OP_QUERY, 0, 5, 59, 0, 1);
    queue_item(OP_QUERY, 0, 6, 0, 0, 1);
    queue_item(OP_QUERY, 0, 31, 63, 0, 1);
    queue_item(OP_QUERY, 1, 0, 0, 0, 1);
    queue_item(OP_QUERY, 6, 21, 59, 0, 1);
    queue_item(OP_CLEAR, 0, 0, 0, 0, 0);
    // Fill Tuesday to capacity, then one more append must be dropped.
    for (k = 0; k <= EventsPerDay; k++) queue_item(OP_APPEND, 2, k, k * 3, k * 100 - 800, 1);
    queue_item(OP_QUERY, 2, 23, 59, 0, 1);

    for (phase = 0; phase < PhaseCount; phase++) begin
      wait_drained();
      case (phase)
        0:       value = -2048;
        1:       value = 2047;
        2:       value = 0;
        3:       value = -1;
        default: value = $urandom_range(0, 4095);
      endcase
      @(negedge clk_i);
      cfg_if.data  <= value[11:0];
      cfg_if.valid <= 1'b1;
      do @(negedge clk_i); while (!cfg_taken);
      cfg_if.valid <= 1'b0;
      @(posedge clk_i);
      no_idle = ($urandom_range(0, 3) == 0);

      made = 0;
      if ($urandom_range(0, 3) != 0) begin
        queue_item(OP_CLEAR, $urandom_range(0, 7), 0, 0, $urandom, $urandom_range(0, 1));
        made++;
      end
      while (made < PhaseItems) begin
        choice = $urandom_range(0, 9);
        if (choice < 3) begin
          // Build part of one day's list, mostly in time order.
          day    = $urandom_range(0, LastDay);
          n      = ($urandom_range(0, 7) == 0) ? $urandom_range(10, EventsPerDay + 2)
                                               : $urandom_range(1, 4);
          sorted = ($urandom_range(0, 4) != 0);
          t      = $urandom_range(0, 300);
          for (k = 0; k < n; k++) begin
            if (sorted) t = t + $urandom_range(0, 120);
            else t = $urandom_range(0, 1439);
            if (t > 1439) t = 1439;
            queue_item(OP_APPEND, day, t / 60, t % 60, $urandom, $urandom_range(0, 1));
          end
          made += n;
        end else if (choice < 9) begin
          t = $urandom_range(0, 1439);
          queue_item(OP_QUERY, $urandom_range(0, LastDay), t / 60, t % 60, $urandom,
                     ($urandom_range(0, 9) != 0));
          made++;
        end else begin
          queue_item(op_e'($urandom_range(0, 3)), $urandom_range(0, 7), $urandom_range(0, 31),
                     $urandom_range(0, 63), $urandom, $urandom_range(0, 1));
          made++;
        end
      end
    end

    wait_drained();
    repeat (DrainCycles) @(negedge clk_i);
    if (error_count == 0 && expected_answers.size() == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/wss_pkg.sv
rtl/wss_if.sv
rtl/wss_event_mem.sv
rtl/weekly_setpoint_schedule_top.sv
bench/testbench.sv
